[hw/rtl/sdra_pkg.sv]
// ----------------------------------------------------------------------------
// sdra_pkg
// Shared constants, command codes and pipeline payload types for the
// scaled decimal row ALU.
// ----------------------------------------------------------------------------
package sdra_pkg;

  localparam int VALUE_W   = 64;
  localparam int HALF_W    = VALUE_W / 2;
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int SCALE_W   = 5;
  localparam int MAX_SCALE = 18;
  localparam int POW_N     = MAX_SCALE + 1;

  // magnitude of the most negative value
  localparam logic [VALUE_W-1:0] MIN_MAG = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_LT  = 3'd3,
    CMD_LE  = 3'd4,
    CMD_GT  = 3'd5,
    CMD_GE  = 3'd6,
    CMD_SEL = 3'd7
  } cmd_t;

  localparam logic [VALUE_W-1:0] POW10 [POW_N] = '{
    64'd1,
    64'd10,
    64'd100,
    64'd1000,
    64'd10000,
    64'd100000,
    64'd1000000,
    64'd10000000,
    64'd100000000,
    64'd1000000000,
    64'd10000000000,
    64'd100000000000,
    64'd1000000000000,
    64'd10000000000000,
    64'd100000000000000,
    64'd1000000000000000,
    64'd10000000000000000,
    64'd100000000000000000,
    64'd1000000000000000000
  };

  // fields that ride along with the multiplier
  typedef struct packed {
    cmd_t                       cmd;
    logic                       neg;
    logic signed [VALUE_W-1:0]  other;
    logic                       scaled_left;
    logic [SCALE_W-1:0]         scale;
    logic                       is_null;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [VALUE_W-1:0] mag_x;
    logic [VALUE_W-1:0] mag_y;
  } op_t;

  typedef struct packed {
    side_t              side;
    logic [VALUE_W-1:0] ll;
    logic [VALUE_W-1:0] lh;
    logic [VALUE_W-1:0] hl;
    logic [VALUE_W-1:0] hh;
  } pp_t;

  typedef struct packed {
    side_t             side;
    logic [PROD_W-1:0] mag;
  } sum_t;

  typedef struct packed {
    side_t                      side;
    logic signed [VALUE_W-1:0]  value;
    logic                       ovf;
  } prod_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic [SCALE_W-1:0]         scale;
    logic                       is_null;
    logic                       cmp;
    logic                       ovf;
  } res_t;

  function automatic logic [VALUE_W-1:0] mag_of(input logic [VALUE_W-1:0] v);
    return v[VALUE_W-1] ? (~v + VALUE_W'(1)) : v;
  endfunction

endpackage

[hw/rtl/sdra_prep.sv]
// ----------------------------------------------------------------------------
// sdra_prep
// Decodes one row: saturates scales, picks the operand to rescale (or the
// two factors of a multiply) and forms the unsigned multiplier operands.
// ----------------------------------------------------------------------------
module sdra_prep (
  input  logic [2:0]                      cmd,
  input  logic signed [63:0]              left_value,
  input  logic [4:0]                      left_digits,
  input  logic                            left_null,
  input  logic signed [63:0]              right_value,
  input  logic [4:0]                      right_digits,
  input  logic                            right_null,
  input  logic                            cond_value,
  input  logic                            cond_unknown,
  output sdra_pkg::op_t                   op
);
  import sdra_pkg::*;

  logic [SCALE_W-1:0] ls;
  logic [SCALE_W-1:0] rs;
  logic [SCALE_W-1:0] big;
  logic [SCALE_W:0]   ssum;
  logic [SCALE_W-1:0] k;
  logic               take;
  logic [VALUE_W-1:0] x;
  cmd_t               c;

  always_comb begin
    c    = cmd_t'(cmd);
    ls   = (left_digits > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : left_digits;
    rs   = (right_digits > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : right_digits;
    big  = (ls > rs) ? ls : rs;
    ssum = {1'b0, ls} + {1'b0, rs};
    take = !cond_unknown && cond_value;
    k    = '0;
    x    = left_value;

    op                  = '0;
    op.side.cmd         = c;
    op.side.scale       = big;
    op.side.is_null     = left_null || right_null;

    unique case (c)
      CMD_MUL: begin
        op.side.scale = (ssum > (SCALE_W+1)'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE)
                                                         : ssum[SCALE_W-1:0];
        op.side.neg   = left_value[VALUE_W-1] ^ right_value[VALUE_W-1];
        op.mag_x      = mag_of(left_value);
        op.mag_y      = mag_of(right_value);
      end
      CMD_SEL: begin
        x               = take ? left_value : right_value;
        k               = big - (take ? ls : rs);
        op.side.is_null = take ? left_null : right_null;
        op.side.neg     = x[VALUE_W-1];
        op.mag_x        = mag_of(x);
        op.mag_y        = POW10[k];
      end
      default: begin
        // only the side with the smaller scale needs the power of ten
        op.side.scaled_left = ls < rs;
        x                   = (ls < rs) ? left_value : right_value;
        op.side.other       = (ls < rs) ? right_value : left_value;
        k                   = (ls < rs) ? (rs - ls) : (ls - rs);
        op.side.neg         = x[VALUE_W-1];
        op.mag_x            = mag_of(x);
        op.mag_y            = POW10[k];
      end
    endcase
  end

endmodule

[hw/rtl/sdra_prod.sv]
// ----------------------------------------------------------------------------
// sdra_prod
// Range check of the 128-bit product magnitude and conversion back to a
// signed 64-bit value.
// ----------------------------------------------------------------------------
module sdra_prod (
  input  sdra_pkg::sum_t  sum,
  output sdra_pkg::prod_t prod
);
  import sdra_pkg::*;

  logic [VALUE_W-1:0] lo;
  logic               fits;

  always_comb begin
    lo   = sum.mag[VALUE_W-1:0];
    // a negative product may reach the most negative value
    fits = (sum.mag[PROD_W-1:VALUE_W] == '0) &&
           (sum.side.neg ? (lo <= MIN_MAG) : !lo[VALUE_W-1]);

    prod.side  = sum.side;
    prod.ovf   = !fits;
    prod.value = '0;
    if (fits) begin
      prod.value = sum.side.neg ? (~lo + VALUE_W'(1)) : lo;
    end
  end

endmodule

[hw/rtl/sdra_post.sv]
// ----------------------------------------------------------------------------
// sdra_post
// Final add, subtract or compare on the aligned operands (multiply and select
// pass through), then null and overflow masking of the result.
// ----------------------------------------------------------------------------
module sdra_post (
  input  sdra_pkg::prod_t prod,
  output sdra_pkg::res_t  res
);
  import sdra_pkg::*;

  logic signed [VALUE_W-1:0] a;
  logic signed [VALUE_W-1:0] b;
  logic signed [VALUE_W:0]   sum;
  logic signed [VALUE_W:0]   diff;
  logic                      lt;
  logic                      eq;
  logic signed [VALUE_W-1:0] val;
  logic                      ovf;
  logic                      cmp;

  always_comb begin
    a    = prod.side.scaled_left ? prod.value : prod.side.other;
    b    = prod.side.scaled_left ? prod.side.other : prod.value;
    sum  = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    diff = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
    lt   = diff[VALUE_W];
    eq   = (diff == '0);
    val  = '0;
    cmp  = 1'b0;
    ovf  = prod.ovf;

    unique case (prod.side.cmd)
      CMD_ADD: begin
        val = sum[VALUE_W-1:0];
        ovf = prod.ovf || (sum[VALUE_W] != sum[VALUE_W-1]);
      end
      CMD_SUB: begin
        val = diff[VALUE_W-1:0];
        ovf = prod.ovf || (diff[VALUE_W] != diff[VALUE_W-1]);
      end
      CMD_MUL, CMD_SEL: val = prod.value;
      CMD_LT:           cmp = lt;
      CMD_LE:           cmp = lt || eq;
      CMD_GT:           cmp = !lt && !eq;
      CMD_GE:           cmp = !lt;
      default:          val = '0;
    endcase

    res.scale   = prod.side.scale;
    res.is_null = prod.side.is_null;
    res.ovf     = ovf;
    res.value   = (ovf || prod.side.is_null) ? '0 : val;
    res.cmp     = cmp && !ovf && !prod.side.is_null;
  end

endmodule

[hw/rtl/scaled_decimal_row_alu.sv]
// the decoded row is registered at the transfer edge; the partial products,
// product sum, range check and final add/compare are each registered in turn
// throughput: one row per cycle while out_stall is low; each stage moves on
// when the next has room
// the 64x64 multiply is split into four 32x32 partial products over two stages
// reset clears all stage valid flags; payload registers are not reset
// ----------------------------------------------------------------------------
// scaled_decimal_row_alu
// Per-row ALU for scaled decimals: add, subtract, multiply, compares and
// case select, rescaled to the larger scale (multiply: summed), int64 overflow flag.
// ----------------------------------------------------------------------------
module scaled_decimal_row_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_cmd,
  input  logic signed [63:0]  in_left_value,
  input  logic [4:0]          in_left_scale,
  input  logic                in_left_null,
  input  logic signed [63:0]  in_right_value,
  input  logic [4:0]          in_right_scale,
  input  logic                in_right_null,
  input  logic                in_cond_value,
  input  logic                in_cond_null,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [63:0]  out_result_value,
  output logic [4:0]          out_result_scale,
  output logic                out_result_null,
  output logic                out_compare_true,
  output logic                out_overflow
);
  import sdra_pkg::*;

  op_t   op_nxt;
  op_t   a_r;
  pp_t   b_r;
  sum_t  c_r;
  prod_t d_r;
  prod_t prod_nxt;
  res_t  res_nxt;
  res_t  o_r;

  logic a_v_r, b_v_r, c_v_r, d_v_r, o_v_r;
  logic adv_a, adv_b, adv_c, adv_d, adv_o;

  pp_t  pp_nxt;
  sum_t sum_nxt;

  // a stage can load when it is empty or its content moves on
  assign adv_o    = !o_v_r || !out_stall;
  assign adv_d    = !d_v_r || adv_o;
  assign adv_c    = !c_v_r || adv_d;
  assign adv_b    = !b_v_r || adv_c;
  assign adv_a    = !a_v_r || adv_b;
  assign in_stall = !adv_a;

  sdra_prep u_prep (
    .cmd          (in_cmd),
    .left_value   (in_left_value),
    .left_digits  (in_left_scale),
    .left_null    (in_left_null),
    .right_value  (in_right_value),
    .right_digits (in_right_scale),
    .right_null   (in_right_null),
    .cond_value   (in_cond_value),
    .cond_unknown (in_cond_null),
    .op           (op_nxt)
  );

  always_comb begin
    pp_nxt.side = a_r.side;
    pp_nxt.ll   = a_r.mag_x[HALF_W-1:0]       * a_r.mag_y[HALF_W-1:0];
    pp_nxt.lh   = a_r.mag_x[HALF_W-1:0]       * a_r.mag_y[VALUE_W-1:HALF_W];
    pp_nxt.hl   = a_r.mag_x[VALUE_W-1:HALF_W] * a_r.mag_y[HALF_W-1:0];
    pp_nxt.hh   = a_r.mag_x[VALUE_W-1:HALF_W] * a_r.mag_y[VALUE_W-1:HALF_W];
  end

  always_comb begin
    sum_nxt.side = b_r.side;
    sum_nxt.mag  = {{VALUE_W{1'b0}}, b_r.ll}
                 + {{HALF_W{1'b0}}, b_r.lh, {HALF_W{1'b0}}}
                 + {{HALF_W{1'b0}}, b_r.hl, {HALF_W{1'b0}}}
                 + {b_r.hh, {VALUE_W{1'b0}}};
  end

  sdra_prod u_prod (
    .sum  (c_r),
    .prod (prod_nxt)
  );

  sdra_post u_post (
    .prod (d_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (adv_a) a_v_r <= in_valid;
      if (adv_b) b_v_r <= a_v_r;
      if (adv_c) c_v_r <= b_v_r;
      if (adv_d) d_v_r <= c_v_r;
      if (adv_o) o_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) a_r <= op_nxt;
    if (adv_b && a_v_r)    b_r <= pp_nxt;
    if (adv_c && b_v_r)    c_r <= sum_nxt;
    if (adv_d && c_v_r)    d_r <= prod_nxt;
    if (adv_o && d_v_r)    o_r <= res_nxt;
  end

  assign out_valid        = o_v_r;
  assign out_result_value = o_r.value;
  assign out_result_scale = o_r.scale;
  assign out_result_null  = o_r.is_null;
  assign out_compare_true = o_r.cmp;
  assign out_overflow     = o_r.ovf;

  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_null |-> out_result_value == '0 && !out_compare_true)
    else $error("null result carries a value or compare outcome");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_result_value == '0 && !out_compare_true)
    else $error("overflowed result is not zero");

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_scale <= SCALE_W'(MAX_SCALE))
    else $error("result scale above maximum");

  a_transfer_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> a_v_r)
    else $error("input transfer lost at decode stage");

  a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    d_v_r && !adv_o |=> d_v_r && $stable(d_r))
    else $error("stage before output register dropped or changed an item");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scaled decimal row ALU. A directed table covers
// the range edges, every command, nulls, scale saturation and overflow; random
// rows follow. Results are predicted in the bench or taken from the table and
// are matched in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdra_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ROWS = 850;
  localparam int N_DIRECTED  = 26;

  localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [63:0] left_value;
    logic [4:0]         left_digits;
    logic               left_null;
    logic signed [63:0] right_value;
    logic [4:0]         right_digits;
    logic               right_null;
    logic               cond_value;
    logic               cond_unknown;
  } row_t;

  typedef struct packed {
    row_t op;
    logic known;
    res_t want;
  } vector_t;

  localparam res_t NO_RES = '0;

  // rows with known = 1 carry their result, the others go through the predictor
  localparam vector_t DIRECTED [N_DIRECTED] = '{
    '{'{CMD_ADD, 64'sd15, 5'd1, 1'b0, 64'sd225, 5'd2, 1'b0, 1'b0, 1'b0},
      1'b0, NO_RES},
    '{'{CMD_ADD, I64_MAX, 5'd0, 1'b0, 64'sd1, 5'd0, 1'b0, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd0, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_ADD, I64_MIN, 5'd0, 1'b0, -64'sd1, 5'd0, 1'b0, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd0, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_SUB, I64_MIN, 5'd0, 1'b0, 64'sd1, 5'd0, 1'b0, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd0, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_SUB, 64'sd0, 5'd0, 1'b0, I64_MIN, 5'd0, 1'b0, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd0, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_SUB, -64'sd1, 5'd0, 1'b0, I64_MIN, 5'd0, 1'b0, 1'b0, 1'b0},
      1'b1, '{I64_MAX, 5'd0, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_SUB, 64'sd12345, 5'd3, 1'b0, -64'sd7, 5'd0, 1'b0, 1'b1, 1'b1},
      1'b0, NO_RES},
    '{'{CMD_MUL, I64_MIN, 5'd0, 1'b0, -64'sd1, 5'd0, 1'b0, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd0, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_MUL, I64_MIN, 5'd0, 1'b0, 64'sd1, 5'd0, 1'b0, 1'b0, 1'b0},
      1'b1, '{I64_MIN, 5'd0, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_MUL, I64_MAX, 5'd0, 1'b0, I64_MAX, 5'd0, 1'b0, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd0, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_MUL, -64'sd25, 5'd10, 1'b0, 64'sd4, 5'd12, 1'b0, 1'b0, 1'b0},
      1'b0, NO_RES},
    '{'{CMD_MUL, 64'sd0, 5'd3, 1'b0, -64'sd5, 5'd2, 1'b0, 1'b0, 1'b0},
      1'b0, NO_RES},
    '{'{CMD_ADD, 64'sd10, 5'd0, 1'b0, 64'sd0, 5'd18, 1'b0, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd18, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_ADD, 64'sd7, 5'd31, 1'b0, 64'sd3, 5'd20, 1'b0, 1'b0, 1'b0},
      1'b0, NO_RES},
    '{'{CMD_LT, 64'sd5, 5'd0, 1'b0, 64'sd50, 5'd1, 1'b0, 1'b0, 1'b0},
      1'b0, NO_RES},
    '{'{CMD_LE, 64'sd5, 5'd0, 1'b0, 64'sd50, 5'd1, 1'b0, 1'b0, 1'b0},
      1'b0, NO_RES},
    '{'{CMD_GT, -64'sd3, 5'd2, 1'b0, -64'sd4, 5'd2, 1'b0, 1'b0, 1'b0},
      1'b0, NO_RES},
    '{'{CMD_GE, I64_MIN, 5'd0, 1'b0, I64_MAX, 5'd0, 1'b0, 1'b0, 1'b0},
      1'b0, NO_RES},
    '{'{CMD_GE, I64_MAX, 5'd0, 1'b0, 64'sd1, 5'd18, 1'b0, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd18, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_ADD, 64'sd1, 5'd2, 1'b1, 64'sd2, 5'd5, 1'b0, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd5, 1'b1, 1'b0, 1'b0}},
    '{'{CMD_LT, 64'sd10, 5'd0, 1'b0, 64'sd0, 5'd18, 1'b1, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd18, 1'b1, 1'b0, 1'b1}},
    '{'{CMD_SEL, 64'sd3, 5'd1, 1'b0, 64'sd5, 5'd4, 1'b0, 1'b1, 1'b0},
      1'b0, NO_RES},
    '{'{CMD_SEL, 64'sd3, 5'd1, 1'b0, 64'sd5, 5'd4, 1'b0, 1'b1, 1'b1},
      1'b0, NO_RES},
    '{'{CMD_SEL, 64'sd3, 5'd1, 1'b0, 64'sd5, 5'd4, 1'b1, 1'b0, 1'b0},
      1'b1, '{64'sd0, 5'd4, 1'b1, 1'b0, 1'b0}},
    '{'{CMD_SEL, I64_MAX, 5'd0, 1'b0, 64'sd1, 5'd5, 1'b0, 1'b1, 1'b0},
      1'b1, '{64'sd0, 5'd5, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_SEL, I64_MAX, 5'd0, 1'b1, 64'sd1, 5'd5, 1'b0, 1'b0, 1'b0},
      1'b0, NO_RES}
  };

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_cmd;
  logic signed [63:0] in_left_value;
  logic [4:0]         in_left_scale;
  logic               in_left_null;
  logic signed [63:0] in_right_value;
  logic [4:0]         in_right_scale;
  logic               in_right_null;
  logic               in_cond_value;
  logic               in_cond_null;
  logic               out_valid;
  logic               out_stall;
  logic signed [63:0] out_result_value;
  logic [4:0]         out_result_scale;
  logic               out_result_null;
  logic               out_compare_true;
  logic               out_overflow;

  res_t pending_results [$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   calm = 1'b0;

  scaled_decimal_row_alu u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_left_value    (in_left_value),
    .in_left_scale    (in_left_scale),
    .in_left_null     (in_left_null),
    .in_right_value   (in_right_value),
    .in_right_scale   (in_right_scale),
    .in_right_null    (in_right_null),
    .in_cond_value    (in_cond_value),
    .in_cond_null     (in_cond_null),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_result_scale (out_result_scale),
    .out_result_null  (out_result_null),
    .out_compare_true (out_compare_true),
    .out_overflow     (out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [63:0] decimal_mul(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     inout logic ovf);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] prod;
    logic [127:0] lim;
    logic         neg;
    ma   = a[63] ? ~a + 64'd1 : a;
    mb   = b[63] ? ~b + 64'd1 : b;
    prod = {64'd0, ma} * {64'd0, mb};
    neg  = (a[63] ^ b[63]) && (prod != 128'd0);
    // a negative product may reach one past the positive limit
    lim  = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
    if (prod > lim) begin
      ovf = 1'b1;
      return '0;
    end
    return neg ? -prod[63:0] : prod[63:0];
  endfunction

  function automatic logic signed [63:0] decimal_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     inout logic ovf);
    logic signed [63:0] sum;
    sum = a + b;
    if (a[63] == b[63] && sum[63] != a[63]) begin
      ovf = 1'b1;
      return '0;
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] rescale_up(input logic signed [63:0] v,
                                                    input int unsigned from_sc,
                                                    input int unsigned to_sc,
                                                    inout logic ovf);
    if (from_sc >= to_sc)
      return v;
    return decimal_mul(v, POW10[to_sc - from_sc], ovf);
  endfunction

  function automatic res_t predict_row(input row_t r);
    res_t               o;
    int unsigned        ls;
    int unsigned        rs;
    int unsigned        big;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic               ovf;
    logic               take;
    ls  = (r.left_digits > MAX_SCALE) ? MAX_SCALE : r.left_digits;
    rs  = (r.right_digits > MAX_SCALE) ? MAX_SCALE : r.right_digits;
    big = (ls > rs) ? ls : rs;
    ovf = 1'b0;
    o   = '0;
    o.scale   = 5'(big);
    o.is_null = r.left_null | r.right_null;
    case (r.cmd)
      CMD_SEL: begin
        take = r.cond_value & ~r.cond_unknown;
        // only the chosen branch is rescaled
        if (take)
          o.value = rescale_up(r.left_value, ls, big, ovf);
        else
          o.value = rescale_up(r.right_value, rs, big, ovf);
        o.is_null = take ? r.left_null : r.right_null;
      end
      CMD_MUL: begin
        o.scale = 5'((ls + rs > MAX_SCALE) ? MAX_SCALE : ls + rs);
        o.value = decimal_mul(r.left_value, r.right_value, ovf);
      end
      default: begin
        a = rescale_up(r.left_value, ls, big, ovf);
        b = rescale_up(r.right_value, rs, big, ovf);
        case (r.cmd)
          CMD_ADD: o.value = decimal_add(a, b, ovf);
          CMD_SUB: begin
            if (b == I64_MIN) begin
              if (!a[63])
                ovf = 1'b1;
              else
                o.value = a + I64_MIN;
            end else begin
              o.value = decimal_add(a, -b, ovf);
            end
          end
          CMD_LT:  o.cmp = (a < b);
          CMD_LE:  o.cmp = (a <= b);
          CMD_GT:  o.cmp = (a > b);
          default: o.cmp = (a >= b);
        endcase
      end
    endcase
    if (ovf || o.is_null) begin
      o.value = '0;
      o.cmp   = 1'b0;
    end
    o.ovf = ovf;
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [63:0] pick_value();
    logic signed [63:0] v;
    case ($urandom_range(0, 7))
      0: v = {$urandom, $urandom};
      1: begin
        case ($urandom_range(0, 4))
          0:       v = I64_MIN;
          1:       v = I64_MAX;
          2:       v = 64'sd0;
          3:       v = 64'sd1;
          default: v = -64'sd1;
        endcase
      end
      2: v = POW10[$urandom_range(0, MAX_SCALE)] + 64'($urandom_range(0, 9));
      3, 4: v = 64'($urandom >> $urandom_range(0, 31));
      default: v = 64'($urandom_range(0, 99999));
    endcase
    if ($urandom_range(0, 1))
      v = -v;
    return v;
  endfunction

  function automatic logic [4:0] pick_scale();
    if ($urandom_range(0, 9) == 0)
      return 5'($urandom_range(MAX_SCALE + 1, 31));
    return 5'($urandom_range(0, MAX_SCALE));
  endfunction

  task automatic send_row(input row_t r, input res_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_cmd         <= r.cmd;
    in_left_value  <= r.left_value;
    in_left_scale  <= r.left_digits;
    in_left_null   <= r.left_null;
    in_right_value <= r.right_value;
    in_right_scale <= r.right_digits;
    in_right_null  <= r.right_null;
    in_cond_value  <= r.cond_value;
    in_cond_null   <= r.cond_unknown;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), want);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    row_t r;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_ADD;
    in_left_value  = '0;
    in_left_scale  = '0;
    in_left_null   = 1'b0;
    in_right_value = '0;
    in_right_scale = '0;
    in_right_null  = 1'b0;
    in_cond_value  = 1'b0;
    in_cond_null   = 1'b0;
    out_stall      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_row(DIRECTED[i].op,
               DIRECTED[i].known ? DIRECTED[i].want : predict_row(DIRECTED[i].op));
    @(negedge clk) in_valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < RANDOM_ROWS; i++) begin
      // back-to-back stretch, and one full drain in the middle
      calm = (i >= 300 && i < 400);
      if (i == 500) begin
        @(negedge clk) in_valid <= 1'b0;
        wait_drained();
      end
      r.cmd          = cmd_t'($urandom_range(0, 7));
      r.left_value   = pick_value();
      r.left_digits  = pick_scale();
      r.left_null    = ($urandom_range(0, 7) == 0);
      r.right_value  = pick_value();
      r.right_digits = pick_scale();
      r.right_null   = ($urandom_range(0, 7) == 0);
      r.cond_value   = 1'($urandom_range(0, 1));
      r.cond_unknown = ($urandom_range(0, 5) == 0);
      send_row(r, predict_row(r));
    end
    @(negedge clk) in_valid <= 1'b0;

    wait_drained();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- result side

  initial begin
    int n;
    wait (rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.value   = out_result_value;
      got.scale   = out_result_scale;
      got.is_null = out_result_null;
      got.cmp     = out_compare_true;
      got.ovf     = out_overflow;
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result transfer: value=%0d scale=%0d",
                   got.value, got.scale);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10)
            $display({"mismatch: exp value=%0d scale=%0d null=%0b cmp=%0b ovf=%0b",
                      " | got value=%0d scale=%0d null=%0b cmp=%0b ovf=%0b"},
                     want.value, want.scale, want.is_null, want.cmp, want.ovf,
                     got.value, got.scale, got.is_null, got.cmp, got.ovf);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

[sim.f]
hw/rtl/sdra_pkg.sv
hw/rtl/sdra_prep.sv
hw/rtl/sdra_prod.sv
hw/rtl/sdra_post.sv
hw/rtl/scaled_decimal_row_alu.sv
bench/tb_top.sv
